// File: rtl/core/g711c_pkg.sv
`timescale 1ns / 1ps

package g711c_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ENCODE    = 2'd0;
  localparam cmd_t CMD_DECODE    = 2'd1;
  localparam cmd_t CMD_TRANSCODE = 2'd2;

  localparam logic LAW_MU = 1'b0;
  localparam logic LAW_A  = 1'b1;

  // 17-bit signed magnitude domain: biased mu-law and offset A-law values
  typedef logic signed [16:0] lin_t;
  typedef logic [6:0]         mag7_t;

  localparam logic [7:0] A_MASK_POS  = 8'hD5;
  localparam logic [7:0] A_MASK_NEG  = 8'h55;
  localparam logic [7:0] MU_MASK_POS = 8'hFF;
  localparam logic [7:0] MU_MASK_NEG = 8'h7F;
  localparam logic [7:0] MAG_MASK    = 8'h7F;

  localparam lin_t        MU_BIAS    = 17'sh00084;
  localparam lin_t        A_NEG_OFS  = 17'sh00008;
  localparam logic [15:0] MU_BIAS16  = 16'h0084;
  localparam logic [15:0] A_SEG_BIAS = 16'h0108;
  localparam logic [15:0] A_SEG0_OFS = 16'h0008;

  localparam lin_t SEG_TOP [8] = '{
    17'sh000FF, 17'sh001FF, 17'sh003FF, 17'sh007FF,
    17'sh00FFF, 17'sh01FFF, 17'sh03FFF, 17'sh07FFF
  };

  // mu-law magnitude code -> A-law magnitude code
  localparam mag7_t MU2A_TAB [128] = '{
    7'd0,   7'd0,   7'd1,   7'd1,   7'd2,   7'd2,   7'd3,   7'd3,
    7'd4,   7'd4,   7'd5,   7'd5,   7'd6,   7'd6,   7'd7,   7'd7,
    7'd8,   7'd9,   7'd10,  7'd11,  7'd12,  7'd13,  7'd14,  7'd15,
    7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
    7'd24,  7'd26,  7'd28,  7'd30,  7'd32,  7'd33,  7'd34,  7'd35,
    7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
    7'd45,  7'd47,  7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,
    7'd54,  7'd55,  7'd56,  7'd57,  7'd58,  7'd59,  7'd60,  7'd61,
    7'd63,  7'd64,  7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,
    7'd71,  7'd72,  7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,
    7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
    7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
    7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
    7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
    7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
    7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
  };

  // A-law magnitude code -> mu-law magnitude code
  localparam mag7_t A2MU_TAB [128] = '{
    7'd1,   7'd3,   7'd5,   7'd7,   7'd9,   7'd11,  7'd13,  7'd15,
    7'd16,  7'd17,  7'd18,  7'd19,  7'd20,  7'd21,  7'd22,  7'd23,
    7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,  7'd31,
    7'd32,  7'd32,  7'd33,  7'd33,  7'd34,  7'd34,  7'd35,  7'd35,
    7'd36,  7'd37,  7'd38,  7'd39,  7'd40,  7'd41,  7'd42,  7'd43,
    7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd48,  7'd49,  7'd49,
    7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
    7'd58,  7'd59,  7'd60,  7'd61,  7'd62,  7'd63,  7'd64,  7'd64,
    7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd72,
    7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd79,
    7'd80,  7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,
    7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd94,  7'd95,
    7'd96,  7'd97,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
    7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
    7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
    7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
  };

  typedef struct packed {
    cmd_t       cmd;
    logic       law;
    logic       sbit;
    lin_t       v;
    logic [7:0] code;
  } s1_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        law;
    logic        sbit;
    logic        sat;
    logic [7:0]  pre;
    logic [15:0] mag;
  } s2_t;

endpackage

// File: rtl/core/g711c_in_if.sv
`timescale 1ns / 1ps

interface g711c_in_if;
  logic               valid;
  logic               ready;
  g711c_pkg::cmd_t    command;
  logic signed [15:0] sample;
  logic [7:0]         code;

  modport source (output valid, command, sample, code, input ready);
  modport sink   (input valid, command, sample, code, output ready);
endinterface

// File: rtl/core/g711c_out_if.sv
`timescale 1ns / 1ps

interface g711c_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_code;
  logic signed [15:0] out_sample;

  modport source (output valid, out_code, out_sample, input ready);
  modport sink   (input valid, out_code, out_sample, output ready);
endinterface

// File: rtl/core/g711c_cfg_if.sv
`timescale 1ns / 1ps

interface g711c_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/g711c_seg.sv
`timescale 1ns / 1ps

module g711c_seg (
  input  g711c_pkg::lin_t v,
  input  logic            law,
  output logic [6:0]      segq,
  output logic            sat
);

  logic [2:0]  seg;
  logic [3:0]  sh;
  logic [16:0] shifted;

  always_comb begin
    seg = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (v <= g711c_pkg::SEG_TOP[i]) begin
        seg = 3'(i);
      end
    end
    sat = (v > g711c_pkg::SEG_TOP[7]);
    if (law == g711c_pkg::LAW_A && seg < 3'd2) begin
      sh = 4'd4;
    end else begin
      sh = {1'b0, seg} + 4'd3;
    end
    shifted = 17'(unsigned'(v)) >> sh;
    segq    = {seg, shifted[3:0]};
  end

endmodule

// File: rtl/core/g711_companding_codec.sv
`timescale 1ns / 1ps

// G.711 A-law / mu-law codec. One beat in, one beat out; a new beat is taken
// every cycle while the pipe is not stalled (three register stages:
// operand prep, segment search / expansion shift / table lookup, sign and
// mask fixup into the output register). Backpressure on the output stalls
// the pipe stage by stage, so bubbles are squeezed out. Write cfg only when
// the pipe is empty; cfg.data = 0 selects mu-law, 1 selects A-law.
module g711_companding_codec (
  input  logic          clk,
  input  logic          rst_n,
  g711c_in_if.sink      in_ch,
  g711c_out_if.source   out_ch,
  g711c_cfg_if.sink     cfg_ch
);

  logic law_r;

  logic              s1_v_r;
  g711c_pkg::s1_t    s1_r;
  g711c_pkg::s1_t    s1_nxt;
  logic              s2_v_r;
  g711c_pkg::s2_t    s2_r;
  g711c_pkg::s2_t    s2_nxt;
  logic              out_v_r;
  logic [7:0]        out_code_r;
  logic [7:0]        out_code_nxt;
  logic signed [15:0] out_sample_r;
  logic signed [15:0] out_sample_nxt;

  logic en1, en2, en3;

  assign en3 = !out_v_r || out_ch.ready;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_ch.ready       = en1;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_v_r;
  assign out_ch.out_code   = out_code_r;
  assign out_ch.out_sample = out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      law_r <= g711c_pkg::LAW_MU;
    end else if (cfg_ch.valid) begin
      law_r <= cfg_ch.data;
    end
  end

  // stage 1: magnitude prep
  g711c_pkg::lin_t s_ext;
  g711c_pkg::lin_t mag;

  always_comb begin
    s_ext = {in_ch.sample[15], in_ch.sample};
    mag   = in_ch.sample[15] ? -s_ext : s_ext;
    s1_nxt.cmd  = in_ch.command;
    s1_nxt.law  = law_r;
    s1_nxt.sbit = in_ch.sample[15];
    s1_nxt.code = in_ch.code;
    if (law_r == g711c_pkg::LAW_A) begin
      s1_nxt.v = in_ch.sample[15] ? mag - g711c_pkg::A_NEG_OFS : mag;
    end else begin
      s1_nxt.v = mag + g711c_pkg::MU_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= s1_nxt;
    end
  end

  // stage 2: segment search, expansion, table lookup
  logic [6:0]  segq;
  logic        seg_sat;
  logic [7:0]  a_byte;
  logic [7:0]  u_byte;
  logic [15:0] ta0;
  logic [15:0] ta;
  logic [15:0] tm;
  logic [6:0]  tab;

  g711c_seg u_seg (
    .v    (s1_r.v),
    .law  (s1_r.law),
    .segq (segq),
    .sat  (seg_sat)
  );

  always_comb begin
    a_byte = s1_r.code ^ g711c_pkg::A_MASK_NEG;
    u_byte = ~s1_r.code;
    ta0    = {8'd0, a_byte[3:0], 4'd0};
    if (a_byte[6:4] == 3'd0) begin
      ta = ta0 + g711c_pkg::A_SEG0_OFS;
    end else begin
      ta = (ta0 + g711c_pkg::A_SEG_BIAS) << (a_byte[6:4] - 3'd1);
    end
    tm = ({9'd0, u_byte[3:0], 3'd0} + g711c_pkg::MU_BIAS16) << u_byte[6:4];

    if (s1_r.law == g711c_pkg::LAW_A) begin
      tab = g711c_pkg::A2MU_TAB[s1_r.code[6:0] ^ g711c_pkg::A_MASK_NEG[6:0]];
    end else begin
      tab = g711c_pkg::MU2A_TAB[~s1_r.code[6:0]];
    end

    s2_nxt.cmd  = s1_r.cmd;
    s2_nxt.law  = s1_r.law;
    s2_nxt.sbit = (s1_r.cmd == g711c_pkg::CMD_ENCODE) ? s1_r.sbit : s1_r.code[7];
    s2_nxt.sat  = seg_sat;
    s2_nxt.mag  = 16'd0;
    case (s1_r.cmd)
      g711c_pkg::CMD_ENCODE: begin
        s2_nxt.pre = {1'b0, segq};
      end
      g711c_pkg::CMD_DECODE: begin
        s2_nxt.pre = 8'd0;
        s2_nxt.mag = (s1_r.law == g711c_pkg::LAW_A) ? ta : tm;
      end
      g711c_pkg::CMD_TRANSCODE: begin
        s2_nxt.pre = {1'b0, tab};
      end
      default: begin
        s2_nxt.pre = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r <= s2_nxt;
    end
  end

  // stage 3: sign / mask fixup
  logic [7:0] enc_mask;
  logic [7:0] trn_mask;

  always_comb begin
    if (s2_r.law == g711c_pkg::LAW_A) begin
      enc_mask = s2_r.sbit ? g711c_pkg::A_MASK_NEG : g711c_pkg::A_MASK_POS;
      trn_mask = s2_r.sbit ? g711c_pkg::MU_MASK_POS : g711c_pkg::MU_MASK_NEG;
    end else begin
      enc_mask = s2_r.sbit ? g711c_pkg::MU_MASK_NEG : g711c_pkg::MU_MASK_POS;
      trn_mask = s2_r.sbit ? g711c_pkg::A_MASK_POS : g711c_pkg::A_MASK_NEG;
    end
    out_code_nxt   = 8'd0;
    out_sample_nxt = 16'sd0;
    case (s2_r.cmd)
      g711c_pkg::CMD_ENCODE: begin
        out_code_nxt = s2_r.sat ? (g711c_pkg::MAG_MASK ^ enc_mask) : (s2_r.pre ^ enc_mask);
      end
      g711c_pkg::CMD_DECODE: begin
        if (s2_r.law == g711c_pkg::LAW_A) begin
          out_sample_nxt = s2_r.sbit ? s2_r.mag : -s2_r.mag;
        end else begin
          out_sample_nxt = s2_r.sbit ? (s2_r.mag - g711c_pkg::MU_BIAS16)
                                     : (g711c_pkg::MU_BIAS16 - s2_r.mag);
        end
      end
      g711c_pkg::CMD_TRANSCODE: begin
        out_code_nxt = s2_r.pre ^ trn_mask;
      end
      default: begin
        out_code_nxt = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en3) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_code_r   <= out_code_nxt;
      out_sample_r <= out_sample_nxt;
    end
  end

`ifndef SYNTH
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_v_r)
    else $error("accepted beat did not enter stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !en2) |=> (s1_v_r && $stable(s1_r)))
    else $error("stage 1 beat lost or changed during stall");

  a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && en3) |=> out_v_r)
    else $error("stage 2 beat did not reach output");
`endif

endmodule
